// File: rtl/dsnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal number parser package
// Shared types and character constants for the decimal number parser.
// ----------------------------------------------------------------------------
package dsnp_pkg;

  localparam int MANT_W  = 60;
  localparam int MDC_W   = 5;
  localparam int CNT_W   = 8;
  localparam int EACC_W  = 10;
  localparam int NET_W   = 12;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;

  localparam logic [EACC_W-1:0] EXP_MAX   = 10'd999;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'd255;
  localparam logic signed [NET_W-1:0] NET_MAX = 12'sd999;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EXP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic                neg;
    logic [MANT_W-1:0]   mant;
    logic [MDC_W-1:0]    mdc;
    logic [CNT_W-1:0]    frac;
    logic [CNT_W-1:0]    extra;
    logic                eneg;
    logic [EACC_W-1:0]   eacc;
    logic                inexact;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:   PH_LEAD,
    neg:     1'b0,
    mant:    '0,
    mdc:     '0,
    frac:    '0,
    extra:   '0,
    eneg:    1'b0,
    eacc:    '0,
    inexact: 1'b0
  };

endpackage

// File: rtl/decimal_scientific_number_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal scientific number parser
// A result is registered at the output once its last character leaves s1.
// Throughput: one character per cycle unless a blocked result stalls the input.
// Reset (rst, synchronous) clears the parse state and empties both registers.
// The parse state also returns to its reset value after every last character.
// ----------------------------------------------------------------------------
module decimal_scientific_number_parser_unit
  import dsnp_pkg::*;
#(
  parameter int MANTISSA_DIGITS = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     end_of_string,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     is_negative,
  output logic [MANT_W-1:0]        mantissa,
  output logic signed [NET_W-1:0]  decimal_exponent,
  output logic                     inexact
);

  logic         s1_valid;
  logic [7:0]   s1_char;
  logic         s1_eos;
  logic         advance;
  logic         emit;
  parse_state_t state;
  parse_state_t state_next;
  logic signed [NET_W-1:0] net;

  assign advance  = s1_valid && (!s1_eos || !out_valid || !out_stall);
  assign emit     = advance && s1_eos;
  assign in_stall = s1_valid && !advance;

  dsnp_next_state #(
    .MANTISSA_DIGITS(MANTISSA_DIGITS)
  ) u_next_state (
    .cur       (state),
    .char_code (s1_char),
    .nxt       (state_next)
  );

  dsnp_net_exp u_net_exp (
    .st  (state_next),
    .net (net)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= char_code;
      s1_eos  <= end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= s1_eos ? STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_negative      <= state_next.neg;
      mantissa         <= state_next.mant;
      decimal_exponent <= net;
      inexact          <= state_next.inexact;
    end
  end

  // A transaction that ends a string leaves the parser in its reset state.
  a_reset_after_emit : assert property (@(posedge clk) disable iff (rst)
    emit |=> (state.phase == PH_LEAD && state.mant == '0 && state.mdc == '0))
    else $error("parse state not cleared after a result");

  // The input side only holds off when a finished result is blocked downstream.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_eos && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // The significant digit count never passes the mantissa capacity.
  a_digit_count : assert property (@(posedge clk) disable iff (rst)
    state.mdc <= MDC_W'(MANTISSA_DIGITS))
    else $error("mantissa digit count out of range");

  // A delivered exponent is saturated at the top of its range.
  a_exp_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (decimal_exponent <= NET_MAX))
    else $error("decimal exponent above saturation limit");

endmodule

// File: rtl/dsnp_next_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser next state
// Applies one character to the parser state, resolving every phase that the
// character falls through in the same cycle.
// ----------------------------------------------------------------------------
module dsnp_next_state
  import dsnp_pkg::*;
#(
  parameter int MANTISSA_DIGITS = 18
) (
  input  parse_state_t cur,
  input  logic [7:0]   char_code,
  output parse_state_t nxt
);

  logic                is_digit;
  logic                is_space;
  logic [3:0]          dig;
  logic [MANT_W-1:0]   mant_x10;
  logic [13:0]         eacc_x10;
  logic                consumed;
  logic                room;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_space = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
  assign dig      = 4'(char_code - CH_ZERO);
  assign mant_x10 = (cur.mant << 3) + (cur.mant << 1) + MANT_W'(dig);
  assign eacc_x10 = (14'(cur.eacc) << 3) + (14'(cur.eacc) << 1) + 14'(dig);
  assign room     = cur.mdc < MDC_W'(MANTISSA_DIGITS);

  always_comb begin
    nxt      = cur;
    consumed = 1'b0;

    if (nxt.phase == PH_LEAD) begin
      if (is_space) begin
        consumed = 1'b1;
      end else begin
        nxt.phase = PH_INT;
        if (char_code == CH_MINUS) begin
          nxt.neg  = 1'b1;
          consumed = 1'b1;
        end else if (char_code == CH_PLUS) begin
          consumed = 1'b1;
        end
      end
    end

    if (!consumed && nxt.phase == PH_INT) begin
      if (is_digit) begin
        consumed = 1'b1;
        if (cur.mdc == '0 && dig == 4'd0) begin
          nxt.mdc = cur.mdc;
        end else if (room) begin
          nxt.mant = mant_x10;
          nxt.mdc  = cur.mdc + 1'b1;
        end else begin
          nxt.inexact = 1'b1;
          if (cur.extra != COUNT_MAX) begin
            nxt.extra = cur.extra + 1'b1;
          end
        end
      end else if (char_code == CH_POINT) begin
        nxt.phase = PH_FRAC;
        consumed  = 1'b1;
      end else begin
        nxt.phase = PH_FRAC;
      end
    end

    if (!consumed && nxt.phase == PH_FRAC) begin
      if (is_digit) begin
        consumed = 1'b1;
        if (cur.mdc == '0 && dig == 4'd0) begin
          if (cur.frac != COUNT_MAX) begin
            nxt.frac = cur.frac + 1'b1;
          end else begin
            nxt.inexact = 1'b1;
          end
        end else if (room && cur.frac != COUNT_MAX) begin
          nxt.mant = mant_x10;
          nxt.mdc  = cur.mdc + 1'b1;
          nxt.frac = cur.frac + 1'b1;
        end else begin
          nxt.inexact = 1'b1;
        end
      end else begin
        nxt.phase = PH_ESIGN;
        if (char_code == CH_LOWER_E || char_code == CH_UPPER_E) begin
          consumed = 1'b1;
        end
      end
    end

    if (!consumed && nxt.phase == PH_ESIGN) begin
      nxt.phase = PH_EXP;
      if (char_code == CH_MINUS) begin
        nxt.eneg = 1'b1;
        consumed = 1'b1;
      end else if (char_code == CH_PLUS) begin
        consumed = 1'b1;
      end
    end

    if (!consumed && nxt.phase == PH_EXP) begin
      if (is_digit) begin
        nxt.eacc = (eacc_x10 > 14'(EXP_MAX)) ? EXP_MAX : EACC_W'(eacc_x10);
      end else begin
        nxt.phase = PH_DONE;
      end
    end
  end

endmodule

// File: rtl/dsnp_net_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Net exponent
// Combines the exponent field, fraction count and extra integer digits into
// the saturated net power of ten.
// ----------------------------------------------------------------------------
module dsnp_net_exp
  import dsnp_pkg::*;
(
  input  parse_state_t             st,
  output logic signed [NET_W-1:0]  net
);

  logic signed [NET_W-1:0] exp_s;
  logic signed [NET_W-1:0] sum;

  assign exp_s = st.eneg ? -$signed(NET_W'(st.eacc)) : $signed(NET_W'(st.eacc));
  assign sum   = exp_s + $signed(NET_W'(st.extra)) - $signed(NET_W'(st.frac));
  assign net   = (sum > NET_MAX) ? NET_MAX : sum;

endmodule
